// File: rtl/ucb1_pkg.sv
// ---------------------------------------------------------------------------
// ucb1_pkg
// Types and constants shared by the UCB1 child selection block.
// ---------------------------------------------------------------------------
package ucb1_pkg;

    localparam int unsigned VisW   = 16;
    localparam int unsigned RewW   = 32;
    localparam int unsigned ScoreW = 37;
    localparam int unsigned IdxW   = 5;
    localparam int unsigned GainW  = 16;

    localparam logic [GainW-1:0]  GAIN_RESET  = 16'd5793;
    localparam logic [ScoreW-1:0] UNVISITED   = 37'(64'd99999 << 16);
    localparam logic [ScoreW-1:0] MINUS_ONE   = 37'h1FFFFF0000;
    localparam logic [31:0]       LN2_Q32     = 32'd2977044472;

    typedef struct packed {
        logic [VisW-1:0] child_visits;
        logic [RewW-1:0] child_reward_sum;
        logic [VisW-1:0] parent_visits;
        logic            last_child;
    } t_in;

    typedef struct packed {
        logic              found;
        logic [IdxW-1:0]   best_index;
        logic [ScoreW-1:0] top_score;
    } t_out;

endpackage

// File: rtl/ucb1_child_select.sv
// ---------------------------------------------------------------------------
// ucb1_child_select
// UCB1 scoring of streamed children with running best selection.
// ---------------------------------------------------------------------------
// Input channel: one child per transaction (i_in_valid / o_in_stall). The
// last_child flag closes a node; that transaction yields one result on the
// output channel (o_out_valid / i_out_stall), all other children yield none.
// Config channel: i_cfg_valid / o_cfg_ready writes exploration_gain (Q4.12).
// A fully scored child occupies the block from acceptance to the next possible
// acceptance for two passes of the bit-serial divider (48 steps plus start and
// handoff) for the mean and the log ratio, 16 serial squarings of the log2
// mantissa, a bit-pair square root, and one state each for ln, gain, compare
// and idle. A parent count below two skips log and ratio. Unvisited and
// skipped children go straight to compare. A last child's result is
// registered in the compare state.
// The result sits in an output register; while it is stalled the next child
// is still taken and scored, only a second result waits for the first.
// Reset (synchronous, active low) restores gain 1.4143 and clears the
// running best to minus one, index zero, not found.
// ---------------------------------------------------------------------------
module ucb1_child_select #(
    parameter int unsigned MAX_CHILDREN = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ucb1_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ucb1_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import ucb1_pkg::*;

    localparam int unsigned PW = $clog2(MAX_CHILDREN + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MEAN = 8'b00000010,
        S_LOG  = 8'b00000100,
        S_LN   = 8'b00001000,
        S_RAT  = 8'b00010000,
        S_SQRT = 8'b00100000,
        S_GAIN = 8'b01000000,
        S_CMP  = 8'b10000000
    } t_state;

    t_state            r_st;
    t_in               r_in;
    logic [GainW-1:0]  r_gain;
    logic [ScoreW-1:0] r_best;
    logic [IdxW-1:0]   r_bidx;
    logic              r_found;
    logic [PW-1:0]     r_pos;
    t_out              r_out;
    logic              r_ov;
    logic [ScoreW-1:0] r_score;
    logic              r_mneg;
    logic [47:0]       r_mean;
    logic [4:0]        r_k;
    logic [31:0]       r_y;
    logic [20:0]       r_l2;
    logic [47:0]       r_v;
    logic [47:0]       r_res;
    logic [47:0]       r_bit;
    logic [31:0]       r_root;
    logic              r_dstart;
    logic [47:0]       r_dnum;

    logic              w_ddone;
    logic [47:0]       w_dquo;
    logic [63:0]       w_sq;
    logic [4:0]        w_top;
    logic [52:0]       w_lnp;
    logic [47:0]       w_exp;
    logic [47:0]       w_trial;
    logic [ScoreW-1:0] w_meanq;
    logic              w_emit;

    ucb1_divu #(.NW(48), .DW(16)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_num  (r_dnum),
        .i_den  (r_in.child_visits),
        .o_done (w_ddone),
        .o_quo  (w_dquo)
    );

    assign w_sq    = {32'd0, r_y} * {32'd0, r_y};
    assign w_lnp   = {32'd0, r_l2} * 53'(LN2_Q32);
    assign w_trial = r_res + r_bit;
    assign w_exp   = ({16'd0, r_root} * {32'd0, r_gain}) >> 12;
    assign w_meanq = r_mneg ? ScoreW'(-r_mean) : ScoreW'(r_mean);

    always_comb begin
        w_top = 5'd0;
        for (int i = 1; i < 16; i++) begin
            if (r_in.parent_visits[i]) w_top = 5'(i);
        end
    end

    assign o_in_stall  = (r_st != S_IDLE) || (r_ov && i_out_stall && i_in_data.last_child);
    assign o_cfg_ready = (r_st == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign w_emit      = (r_st == S_CMP) && r_in.last_child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_gain   <= GAIN_RESET;
            r_best   <= MINUS_ONE;
            r_bidx   <= '0;
            r_found  <= 1'b0;
            r_pos    <= '0;
            r_ov     <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_gain <= i_cfg_data;
            case (r_st)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_in <= i_in_data;
                        if (r_pos >= PW'(MAX_CHILDREN)) begin
                            r_score <= MINUS_ONE;
                            r_st    <= S_CMP;
                        end else if (i_in_data.child_visits == '0) begin
                            r_score <= UNVISITED;
                            r_st    <= S_CMP;
                        end else begin
                            r_mneg   <= i_in_data.child_reward_sum[31];
                            r_dnum   <= {(i_in_data.child_reward_sum[31] ?
                                         32'(-i_in_data.child_reward_sum) :
                                         i_in_data.child_reward_sum), 16'd0} >> 16;
                            r_dstart <= 1'b1;
                            r_st     <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    if (w_ddone) begin
                        r_mean <= w_dquo;
                        r_y    <= 32'({16'd0, r_in.parent_visits} << (5'd30 - w_top));
                        r_l2   <= {w_top, 16'd0};
                        r_k    <= 5'd15;
                        r_st   <= (r_in.parent_visits >= 16'd2) ? S_LOG : S_SQRT;
                        r_v    <= '0;
                        r_res  <= '0;
                        r_bit  <= 48'd1 << 46;
                    end
                end
                S_LOG: begin
                    if (w_sq[61:30] >= 32'h80000000) begin
                        r_y  <= w_sq[62:31];
                        r_l2 <= r_l2 | (21'd1 << r_k);
                    end else begin
                        r_y  <= w_sq[61:30];
                    end
                    r_k <= r_k - 5'd1;
                    if (r_k == 5'd0) r_st <= S_LN;
                end
                S_LN: begin
                    r_dnum   <= 48'(w_lnp >> 32);
                    r_dstart <= 1'b1;
                    r_st     <= S_RAT;
                end
                S_RAT: begin
                    if (w_ddone) begin
                        r_v  <= w_dquo << 16;
                        r_st <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_root <= 32'(r_res);
                        r_st   <= S_GAIN;
                    end else begin
                        if (r_v >= w_trial) begin
                            r_v   <= r_v - w_trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_GAIN: begin
                    r_score <= w_meanq + ScoreW'(w_exp);
                    r_st    <= S_CMP;
                end
                S_CMP: begin
                    r_st <= S_IDLE;
                    if (w_emit) begin
                        r_ov <= 1'b1;
                        if (r_pos < PW'(MAX_CHILDREN) &&
                            $signed(r_score) > $signed(r_best)) begin
                            r_out <= '{found: 1'b1, best_index: IdxW'(r_pos),
                                       top_score: r_score};
                        end else begin
                            r_out <= '{found: r_found, best_index: r_bidx,
                                       top_score: r_best};
                        end
                        r_best  <= MINUS_ONE;
                        r_bidx  <= '0;
                        r_found <= 1'b0;
                        r_pos   <= '0;
                    end else if (r_pos < PW'(MAX_CHILDREN)) begin
                        if ($signed(r_score) > $signed(r_best)) begin
                            r_best  <= r_score;
                            r_bidx  <= IdxW'(r_pos);
                            r_found <= 1'b1;
                        end
                        r_pos <= r_pos + 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/ucb1_divu.sv
// ---------------------------------------------------------------------------
// ucb1_divu
// Radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ucb1_divu #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_sh;

    assign n_sh   = {r_rem[DW-1:0], r_q[NW-1]};
    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (n_sh >= {1'b0, r_den}) begin
                    r_rem <= n_sh - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: rtl/ucb1_checker.sv
// ---------------------------------------------------------------------------
// ucb1_checker
// Port-level checks for the UCB1 child selection block.
// ---------------------------------------------------------------------------
module ucb1_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ucb1_pkg::t_out o_out_data,
    input logic           o_cfg_ready
);
    import ucb1_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_found_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.top_score == MINUS_ONE && o_out_data.best_index == '0)
        else $error("not found result not at reset values");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !o_in_stall || (o_out_valid && i_out_stall))
        else $error("config ready while busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind ucb1_child_select ucb1_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data),
    .o_cfg_ready(o_cfg_ready)
);

// File: sim/ucb1_child_select_tb.sv
// ---------------------------------------------------------------------------
// ucb1_child_select_tb
// Streams child records of tree nodes into the UCB1 selector, predicts the
// best child of each node in fixed point and checks every result field.
// ---------------------------------------------------------------------------
module ucb1_child_select_tb;
    import ucb1_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    ucb1_child_select i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    localparam int MAX_KIDS    = 32;
    localparam int STALL_LIMIT = 20000;

    // predictor state
    logic [15:0]       gain;
    logic signed [63:0] best_sc;
    logic [4:0]        best_ix;
    logic              best_ok;
    int                kid_pos;

    t_out        pending_best[$];
    int          mismatches;
    int          nodes_checked;
    int          children_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;
    logic        timed_out;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] ln_fixed(input logic [15:0] p);
        int          top;
        logic [63:0] y;
        logic [63:0] l2;
        logic [63:0] prod;
        top = 0;
        while (top < 15 && (p >> (top + 1)) != 0) top++;
        l2 = 64'(top) << 16;
        y = 64'(p) << (30 - top);
        for (int k = 15; k >= 0; k--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                l2[k] = 1'b1;
            end
        end
        prod = l2 * 64'(LN2_Q32);
        return prod >> 32;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] child_score(input t_in c);
        logic signed [63:0] mean;
        logic [63:0]        ratio;
        logic [63:0]        expl;
        if (c.child_visits == 0) return 64'sd99999 <<< 16;
        mean = $signed(64'($signed(c.child_reward_sum))) / $signed({48'd0, c.child_visits});
        ratio = 0;
        if (c.parent_visits >= 2) ratio = ln_fixed(c.parent_visits) / 64'(c.child_visits);
        expl = (int_sqrt(ratio << 16) * 64'(gain)) >> 12;
        return mean + $signed(expl);
    endfunction

    function automatic void clear_best();
        best_sc = -64'sd65536;
        best_ix = 0;
        best_ok = 1'b0;
        kid_pos = 0;
    endfunction

    function automatic void predict_child(input t_in c);
        logic signed [63:0] s;
        t_out r;
        if (kid_pos < MAX_KIDS) begin
            s = child_score(c);
            if (s > best_sc) begin
                best_sc = s;
                best_ix = kid_pos[4:0];
                best_ok = 1'b1;
            end
            kid_pos++;
        end
        if (c.last_child) begin
            r.found = best_ok;
            r.best_index = best_ix;
            r.top_score = best_sc[ScoreW-1:0];
            pending_best.push_back(r);
            clear_best();
        end
    endfunction

    // receiver stall and result checking
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_best.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", o_out_data);
                end else begin
                    e = pending_best.pop_front();
                    nodes_checked++;
                    if (o_out_data.found !== e.found || o_out_data.best_index !== e.best_index
                        || o_out_data.top_score !== e.top_score) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("node %0d: exp found=%b idx=%0d score=%h, got %b %0d %h",
                                     nodes_checked, e.found, e.best_index, e.top_score,
                                     o_out_data.found, o_out_data.best_index,
                                     o_out_data.top_score);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out <= 1'b1;
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_child(input t_in c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= c;
        do @(posedge i_clk); while (o_in_stall);
        predict_child(c);
        children_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_best.size() != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [15:0] g);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        do @(posedge i_clk); while (!o_cfg_ready);
        gain = g;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in rand_child(input logic lst);
        t_in c;
        case ($urandom_range(3))
            0: c.child_visits = 16'($urandom_range(3));
            1: c.child_visits = 16'hFFFF - 16'($urandom_range(3));
            default: c.child_visits = 16'($urandom);
        endcase
        c.child_reward_sum = $urandom;
        if ($urandom_range(3) == 0) c.child_reward_sum = $signed(32'($urandom_range(65536*4))) - 131072;
        case ($urandom_range(3))
            0: c.parent_visits = 16'($urandom_range(2));
            1: c.parent_visits = 16'hFFFF;
            default: c.parent_visits = 16'($urandom);
        endcase
        c.last_child = lst;
        return c;
    endfunction

    function automatic t_in mk(input logic [15:0] v, input logic [31:0] r,
                               input logic [15:0] p, input logic l);
        t_in c;
        c.child_visits = v;
        c.child_reward_sum = r;
        c.parent_visits = p;
        c.last_child = l;
        return c;
    endfunction

    task automatic test_directed();
        send_child(mk(16'd0, 32'd0, 16'd0, 1'b1));               // unvisited alone
        send_child(mk(16'd1, 32'h8000_0000, 16'd1, 1'b1));       // nothing above -1
        send_child(mk(16'd1, 32'h7FFF_FFFF, 16'd0, 1'b0));
        send_child(mk(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        send_child(mk(16'd1, 32'h7FFF_FFFF, 16'd0, 1'b1));       // tie: first wins
        send_child(mk(16'd3, 32'h0003_0000, 16'd2, 1'b0));
        send_child(mk(16'd1, 32'hFFFF_0000, 16'd1, 1'b0));       // exactly -1
        send_child(mk(16'd7, 32'h1234_5678, 16'd1000, 1'b1));
        send_child(mk(16'd1, 32'hFFFF_0000, 16'd65535, 1'b1));
        send_child(mk(16'd2, 32'hFFFE_0000, 16'd0, 1'b1));
    endtask

    task automatic test_overflow_node();
        for (int i = 0; i < 36; i++)
            send_child(rand_child(i == 35));
        for (int i = 0; i < 33; i++)
            send_child(mk(16'd0, 32'd0, 16'd0, i == 32));
    endtask

    task automatic test_random(input int n);
        int len;
        int k;
        k = 0;
        while (k < n) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 6);
            for (int j = 0; j < len; j++) send_child(rand_child(j == len - 1));
            k += len;
            if ($urandom_range(19) == 0) drain();   // sender waits for all results
        end
    endtask

    task automatic test_gains();
        write_gain(16'd0);
        test_random(60);
        write_gain(16'hFFFF);
        test_random(60);
        write_gain(16'd1);
        test_random(40);
        write_gain(GAIN_RESET);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_out_stall = 1'b0;
        mismatches = 0;
        nodes_checked = 0;
        children_sent = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gain = GAIN_RESET;
        clear_best();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 49;
        test_directed();
        test_overflow_node();
        test_random(250);
        test_gains();
        send_idle_pct = 49;
        recv_idle_pct = 11;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        drain();

        $display("Scored %0d children across %0d nodes, gains 0, 1, reset and max.",
                 children_sent, nodes_checked);
        if (mismatches == 0 && pending_best.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_best.size());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
